[hw/rtl/phpd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// phpd_pkg: shared types and constants of the piezo hit peak detector
// Sample and result payloads, the configuration register set and its codes.
// ----------------------------------------------------------------------------
package phpd_pkg;

	// Converter sample width
	localparam int SAMPLE_BITS = 10;
	localparam int TIME_W      = 32;
	localparam int WIN_W       = 8;
	localparam int GAIN_W      = 11;
	localparam int VEL_W       = 21;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = (SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_HIT_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_HIT_MS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_MS   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_GAIN      = 2'd3;

	// Reset values and limits
	localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RST = SAMPLE_BITS'(10);
	localparam logic [WIN_W-1:0]       DOUBLE_HIT_RST = 8'd50;
	localparam logic [WIN_W-1:0]       RESPONSE_RST   = 8'd5;
	localparam logic [GAIN_W-1:0]      GAIN_RST       = 11'd256;
	localparam logic [GAIN_W-1:0]      GAIN_MAX       = 11'd1280;
	localparam logic [VEL_W-1:0]       VEL_MAX        = {VEL_W{1'b1}};

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample_level;
		logic [TIME_W-1:0]      time_ms;
	} sample_t;

	typedef struct packed {
		logic             hit;
		logic [VEL_W-1:0] velocity;
		logic             drain;
	} result_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] hit_threshold;
		logic [WIN_W-1:0]       double_hit_ms;
		logic [WIN_W-1:0]       response_ms;
		logic [GAIN_W-1:0]      pad_gain;
	} cfg_t;

endpackage
`default_nettype wire

[hw/rtl/phpd_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// phpd_cfg: configuration register file
// Holds threshold, retrigger window, response time and pad gain; the gain is
// clamped to 5.0 in Q8 on write.
// ----------------------------------------------------------------------------
module phpd_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [phpd_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [phpd_pkg::CFG_DATA_W-1:0]  wr_data,
	output phpd_pkg::cfg_t                        cfg
);

	phpd_pkg::cfg_t               cfg_q;
	logic [phpd_pkg::GAIN_W-1:0]  gain_wr;

	// Clamp the written gain to its maximum
	always_comb begin
		gain_wr = wr_data[phpd_pkg::GAIN_W-1:0];
		if (gain_wr > phpd_pkg::GAIN_MAX) begin
			gain_wr = phpd_pkg::GAIN_MAX;
		end
	end

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hit_threshold <= phpd_pkg::THRESHOLD_RST;
			cfg_q.double_hit_ms <= phpd_pkg::DOUBLE_HIT_RST;
			cfg_q.response_ms   <= phpd_pkg::RESPONSE_RST;
			cfg_q.pad_gain      <= phpd_pkg::GAIN_RST;
		end else if (wr_en) begin
			case (wr_index)
				phpd_pkg::REG_HIT_THRESHOLD: begin
					cfg_q.hit_threshold <= wr_data[phpd_pkg::SAMPLE_BITS-1:0];
				end
				phpd_pkg::REG_DOUBLE_HIT_MS: begin
					cfg_q.double_hit_ms <= wr_data[phpd_pkg::WIN_W-1:0];
				end
				phpd_pkg::REG_RESPONSE_MS: begin
					cfg_q.response_ms <= wr_data[phpd_pkg::WIN_W-1:0];
				end
				phpd_pkg::REG_PAD_GAIN: begin
					cfg_q.pad_gain <= gain_wr;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[hw/rtl/piezo_hit_peak_detector_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// piezo_hit_peak_detector_unit: piezo drum trigger peak detector
// Suppresses retrigger ghosts, tracks the strike peak and reports hit velocity.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel: one converter reading plus a millisecond timestamp per
//   transfer (sample_valid high, sample_stall low). Every sample gives exactly
//   one result on the result channel: hit with velocity, or drain for a ghost,
//   or neither.
//   cfg channel: register index and data; cfg_ready is always high. Write it
//   only while no sample is in flight.
//   Flow: a transferred sample is held in the input register, its result is
//   computed in one pass and registered in the output register, from which
//   it is transferred. Throughput is one sample per cycle while no result
//   stalls; the loop through the peak and last-hit state closes in that pass.
//   A stalled result holds the output register; the input register keeps one
//   more sample, after which sample_stall rises until the result moves.
//   Reset clears the peak, strike and last-hit state and loads the default
//   threshold 10, window 50 ms, response 5 ms and gain 1.0.
// ----------------------------------------------------------------------------
module piezo_hit_peak_detector_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             sample_valid,
	output logic                                  sample_stall,
	input  wire phpd_pkg::sample_t                sample,
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output phpd_pkg::result_t                     result,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [phpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [phpd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int S    = phpd_pkg::SAMPLE_BITS;
	localparam int PW   = S + phpd_pkg::GAIN_W;
	localparam int L4W  = PW + 2;

	phpd_pkg::cfg_t     cfg;
	phpd_pkg::sample_t  item_s1;
	logic               valid_s1;
	phpd_pkg::result_t  result_q;
	logic               result_valid_q;
	logic               advance;
	logic               fire;

	logic [S-1:0]                   peak_q;
	logic [phpd_pkg::TIME_W-1:0]    strike_q;
	logic [phpd_pkg::TIME_W-1:0]    last_hit_q;
	logic [phpd_pkg::VEL_W-1:0]     last_vel_q;

	logic [phpd_pkg::TIME_W-1:0]    elapsed;
	logic [phpd_pkg::WIN_W+1:0]     win4;
	logic [S:0]                     diff;
	logic [PW-1:0]                  lvl_prod;
	logic [L4W-1:0]                 lvl4;
	logic                           ghost;
	logic [S-1:0]                   thr;
	logic [S-1:0]                   s_lvl;
	logic                           start;
	logic [S-1:0]                   peak_new;
	logic [phpd_pkg::TIME_W-1:0]    strike_new;
	logic [phpd_pkg::TIME_W-1:0]    since_strike;
	logic                           report;
	logic [PW-1:0]                  vel_prod;
	logic [phpd_pkg::VEL_W-1:0]     vel;
	phpd_pkg::result_t              res_next;

	// Configuration registers
	assign cfg_ready = 1'b1;

	phpd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Handshake: the input register moves on when the output register is free
	assign advance      = !result_valid_q || !result_stall;
	assign sample_stall = valid_s1 && !advance;
	assign fire         = valid_s1 && advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_valid && !sample_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			item_s1 <= sample;
		end
	end

	assign thr   = cfg.hit_threshold;
	assign s_lvl = item_s1.sample_level;

	// Ghost test against the last reported hit; a level below threshold scales
	// to a negative value, or to zero when the gain is zero
	always_comb begin
		elapsed  = item_s1.time_ms - last_hit_q;
		win4     = {cfg.double_hit_ms, 2'b00};
		diff     = {1'b0, s_lvl} - {1'b0, thr};
		lvl_prod = diff[S-1:0] * cfg.pad_gain;
		lvl4     = {lvl_prod, 2'b00};
		ghost    = (elapsed < phpd_pkg::TIME_W'(cfg.double_hit_ms)) ||
			((elapsed < phpd_pkg::TIME_W'(win4)) &&
			(diff[S] ? ((cfg.pad_gain != '0) || (last_vel_q != '0)) :
			(lvl4 < L4W'(last_vel_q))));
	end

	// Track the peak from the first sample at or above threshold
	always_comb begin
		start      = 1'b0;
		peak_new   = peak_q;
		strike_new = strike_q;
		if ((s_lvl < thr) && (peak_q < thr)) begin
			peak_new = peak_q;
		end else if ((s_lvl >= thr) && (peak_q == '0)) begin
			start      = 1'b1;
			peak_new   = s_lvl;
			strike_new = item_s1.time_ms;
		end else if (s_lvl > peak_q) begin
			peak_new = s_lvl;
		end
		since_strike = start ? '0 : (item_s1.time_ms - strike_q);
		report = (peak_new != '0) &&
			(since_strike > phpd_pkg::TIME_W'(cfg.response_ms));
	end

	// Velocity: (peak - threshold) * gain, clamped at zero and at full scale
	always_comb begin
		vel_prod = (peak_new - thr) * cfg.pad_gain;
		if (peak_new <= thr) begin
			vel = '0;
		end else if (vel_prod > PW'(phpd_pkg::VEL_MAX)) begin
			vel = phpd_pkg::VEL_MAX;
		end else begin
			vel = vel_prod[phpd_pkg::VEL_W-1:0];
		end
		res_next.hit      = !ghost && report;
		res_next.velocity = (!ghost && report) ? vel : '0;
		res_next.drain    = ghost;
	end

	// Advance the detector state on each transfer that is not a ghost
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q     <= '0;
			strike_q   <= '0;
			last_hit_q <= '0;
			last_vel_q <= '0;
		end else if (fire && !ghost) begin
			strike_q <= strike_new;
			if (report) begin
				peak_q     <= '0;
				last_hit_q <= item_s1.time_ms;
				last_vel_q <= vel;
			end else begin
				peak_q <= peak_new;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= res_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Checks
	a_hit_excl_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> !(result_q.hit && result_q.drain))
		else $error("hit and drain reported together");

	a_drain_no_vel: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_q.hit) |-> (result_q.velocity == '0))
		else $error("velocity nonzero without a hit");

	a_hit_clears_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_next.hit) |=> (peak_q == '0))
		else $error("peak not cleared after a hit");

	a_ghost_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ghost) |=> ($stable(peak_q) && $stable(last_hit_q) &&
		$stable(last_vel_q)))
		else $error("ghost sample changed detector state");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (valid_s1 && result_valid_q))
		else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire
